>>> design/lap5_pkg.sv
package lap5_pkg;

    // Default depth of each row store.
    localparam int DEF_MAX_WIDTH = 1024;

    // Datapath widths.
    localparam int DATA_W     = 32;
    localparam int NUM_W      = 34;
    localparam int DEN_W      = 21;
    localparam int QUO_W      = 35;
    localparam int ROW_W      = 16;
    localparam int OUT_COL_W  = 10;
    localparam int STEP_W     = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_STEP_X  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_STEP_Z  = 3'd3;

    // Reset values of the registers.
    localparam logic [10:0] RST_IMAGE_WIDTH  = 11'd1024;
    localparam logic [15:0] RST_IMAGE_HEIGHT = 16'd1024;
    localparam logic [10:0] RST_GRID_STEP    = 11'd1;
    localparam logic [10:0] STEP_MAX         = 11'd1024;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_WR0,
        ST_WR1,
        ST_DIVX,
        ST_DIVZ,
        ST_EMIT
    } state_t;

    // Divider status seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

>>> design/lap5_ram.sv
module lap5_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> design/lap5_div.sv
module lap5_div (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic signed [lap5_pkg::NUM_W-1:0]      num,
    input  logic [lap5_pkg::DEN_W-1:0]             den,
    output lap5_pkg::div_stat_t                    stat,
    output logic signed [lap5_pkg::QUO_W-1:0]      quo
);

    localparam int NW = lap5_pkg::NUM_W;
    localparam int DW = lap5_pkg::DEN_W;
    localparam int QW = lap5_pkg::QUO_W;
    localparam logic [5:0] LAST_STEP = 6'(NW - 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [5:0]    cnt_reg, cnt_next;
    logic [NW-1:0] mag_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] den_reg;
    logic          neg_reg;
    logic signed [QW-1:0] quo_reg;

    logic [DW:0]   trial;
    logic          qbit;
    logic [DW:0]   diff;
    logic [NW-1:0] mag_step;
    logic [NW-1:0] num_abs;

    // One quotient bit per cycle: shift in the next numerator bit and try a subtract.
    always_comb
    begin
        trial    = {rem_reg, mag_reg[NW-1]};
        diff     = trial - {1'b0, den_reg};
        qbit     = (trial >= {1'b0, den_reg});
        mag_step = {mag_reg[NW-2:0], qbit};
        num_abs  = num[NW-1] ? NW'(-num) : NW'(num);
    end

    // Control of the iteration.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (busy_reg)
        begin
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Shift registers of the bit-serial datapath.
    always_ff @(posedge clk)
    begin
        if (!busy_reg && start)
        begin
            mag_reg <= num_abs;
            rem_reg <= '0;
            den_reg <= den;
            neg_reg <= num[NW-1];
        end
        else if (busy_reg)
        begin
            mag_reg <= mag_step;
            rem_reg <= qbit ? diff[DW-1:0] : trial[DW-1:0];
            if (cnt_reg == LAST_STEP)
            begin
                quo_reg <= neg_reg ? -$signed({1'b0, mag_step}) : $signed({1'b0, mag_step});
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quo       = quo_reg;

endmodule

>>> design/laplacian_five_point_stencil.sv
// Five-point Laplacian over a raster-ordered stream of signed Q16.16 samples.
// Input channel: in_valid / in_stall with sample; a transaction moves one sample.
// Output channel: out_valid / out_stall with lap_value, out_row, out_col and
// run_last; run_last marks the last result that one input sample causes.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data.
// The user must write them only while the block is idle; the block does not
// enforce this, and cfg_ready is always high. A write of image_width or
// image_height restarts the frame at row 0, column 0. Each sample passes
// through row-store reads in ST_RD0, ST_RD1 and ST_RD2, writes in ST_WR0 and
// ST_WR1 and two 34-step divisions that share one bit-serial divider; ST_EMIT
// then issues its results in turn. A sample causes zero to four results.
// in_stall is high from acceptance until the last result
// has entered the output register, so the next sample is taken while that
// result still waits. A stalled output register holds its transaction.
// After reset the frame position and the left neighbor are zero, the registers
// hold their reset values and no result is pending; the row stores hold
// nothing valid until the first rows of a frame have been written.
module laplacian_five_point_stencil #(
    parameter int MAX_WIDTH = lap5_pkg::DEF_MAX_WIDTH
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic signed [lap5_pkg::DATA_W-1:0]      sample,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [lap5_pkg::DATA_W-1:0]      lap_value,
    output logic [lap5_pkg::ROW_W-1:0]              out_row,
    output logic [lap5_pkg::OUT_COL_W-1:0]          out_col,
    output logic                                    run_last,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [lap5_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [lap5_pkg::CFG_DATA_W-1:0]         cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = CW + 1;
    localparam int DW = lap5_pkg::DATA_W;
    localparam int NW = lap5_pkg::NUM_W;
    localparam int QW = lap5_pkg::QUO_W;
    localparam int RW = lap5_pkg::ROW_W;

    lap5_pkg::state_t state_reg, state_next;

    logic [10:0]   image_width_reg;
    logic [15:0]   image_height_reg;
    logic [10:0]   step_x_reg;
    logic [10:0]   step_z_reg;
    logic [RW-1:0] row_count_reg;
    logic [CW-1:0] col_count_reg;
    logic [DW-1:0] left_sample_reg;

    // Per-transaction working registers.
    logic [DW-1:0] samp_reg;
    logic [DW-1:0] left_old_reg;
    logic [RW-1:0] r_reg;
    logic [CW-1:0] c_reg;
    logic [3:0]    pend_reg;
    logic          interior_reg;
    logic          last_col_reg;
    logic [DW-1:0] ce_reg, up_reg, rt_reg, lf_reg;
    logic signed [QW-1:0] qx_reg;
    logic [DW-1:0] val_reg;

    // Output register.
    logic          out_valid_reg;
    logic [DW-1:0] lap_value_reg;
    logic [RW-1:0] out_row_reg;
    logic [lap5_pkg::OUT_COL_W-1:0] out_col_reg;
    logic          run_last_reg;

    // Effective geometry and spacing.
    logic [31:0]   iw32;
    logic [WW-1:0] w_eff;
    logic [RW-1:0] h_eff;
    logic [CW-1:0] wlast;
    logic [10:0]   sx_cl, sz_cl;
    logic [lap5_pkg::DEN_W-1:0] sq_x, sq_z;
    logic [CW-1:0] c_cl;
    logic [RW-1:0] r_cl;
    logic          accept;
    logic          cfg_write;
    logic          geo_write;

    always_comb
    begin
        iw32 = 32'(image_width_reg);
        if (iw32 < 32'd3)
        begin
            w_eff = WW'(3);
        end
        else if (iw32 > 32'(MAX_WIDTH))
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(iw32);
        end
        h_eff = (image_height_reg < 16'd3) ? 16'd3 : image_height_reg;
        wlast = CW'(w_eff - WW'(1));
        sx_cl = (step_x_reg == 11'd0) ? 11'd1 :
                (step_x_reg > lap5_pkg::STEP_MAX) ? lap5_pkg::STEP_MAX : step_x_reg;
        sz_cl = (step_z_reg == 11'd0) ? 11'd1 :
                (step_z_reg > lap5_pkg::STEP_MAX) ? lap5_pkg::STEP_MAX : step_z_reg;
        sq_x  = lap5_pkg::DEN_W'(sx_cl) * lap5_pkg::DEN_W'(sx_cl);
        sq_z  = lap5_pkg::DEN_W'(sz_cl) * lap5_pkg::DEN_W'(sz_cl);
        c_cl  = ({1'b0, col_count_reg} >= w_eff) ? wlast : col_count_reg;
        r_cl  = (row_count_reg >= h_eff) ? (h_eff - 16'd1) : row_count_reg;
    end

    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign geo_write = cfg_write && (cfg_index inside {lap5_pkg::CFG_IMAGE_WIDTH,
                                                       lap5_pkg::CFG_IMAGE_HEIGHT});

    // Row stores and the shared divider.
    logic          prev_we, prev2_we;
    logic [CW-1:0] prev_waddr, prev2_waddr, prev_raddr, prev2_raddr;
    logic [DW-1:0] prev_wdata, prev2_wdata, prev_rdata, prev2_rdata;
    logic          div_start;
    logic signed [NW-1:0] div_num;
    logic [lap5_pkg::DEN_W-1:0] div_den;
    lap5_pkg::div_stat_t div_stat;
    logic signed [QW-1:0] div_quo;

    lap5_ram #(.WIDTH(DW), .DEPTH(MAX_WIDTH)) u_row_prev (
        .clk   (clk),
        .we    (prev_we),
        .waddr (prev_waddr),
        .wdata (prev_wdata),
        .raddr (prev_raddr),
        .rdata (prev_rdata)
    );

    lap5_ram #(.WIDTH(DW), .DEPTH(MAX_WIDTH)) u_row_prev2 (
        .clk   (clk),
        .we    (prev2_we),
        .waddr (prev2_waddr),
        .wdata (prev2_wdata),
        .raddr (prev2_raddr),
        .rdata (prev2_rdata)
    );

    lap5_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .stat  (div_stat),
        .quo   (div_quo)
    );

    // Second differences along the row and along the column.
    logic signed [NW-1:0] num_x, num_z;
    always_comb
    begin
        num_x = NW'($signed(lf_reg)) + NW'($signed(rt_reg)) - (NW'($signed(ce_reg)) <<< 1);
        num_z = NW'($signed(up_reg)) + NW'($signed(left_old_reg))
                - (NW'($signed(ce_reg)) <<< 1);
    end

    // Result selection from the pending mask, lowest first.
    logic          out_free;
    logic [1:0]    sel;
    logic [3:0]    pend_after;
    logic [DW-1:0] emit_val;
    logic [RW-1:0] emit_row;
    logic [CW-1:0] emit_col;
    logic [31:0]   emit_col32;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        if (pend_reg[0])
        begin
            sel = 2'd0;
        end
        else if (pend_reg[1])
        begin
            sel = 2'd1;
        end
        else if (pend_reg[2])
        begin
            sel = 2'd2;
        end
        else
        begin
            sel = 2'd3;
        end
        pend_after = pend_reg & ~(4'b0001 << sel);
        case (sel)
            2'd0:
            begin
                emit_val = val_reg;
                emit_row = r_reg - 16'd1;
                emit_col = c_reg - CW'(1);
            end
            2'd1:
            begin
                emit_val = '0;
                emit_row = r_reg - 16'd1;
                emit_col = wlast;
            end
            2'd2:
            begin
                emit_val = '0;
                emit_row = h_eff - 16'd1;
                emit_col = c_reg - CW'(1);
            end
            default:
            begin
                emit_val = '0;
                emit_row = h_eff - 16'd1;
                emit_col = wlast;
            end
        endcase
        emit_col32 = 32'(emit_col);
    end

    // Sum of the two quotients, saturated to 32 bits.
    logic signed [QW:0] qsum;
    logic [DW-1:0]      qsat;
    always_comb
    begin
        qsum = (QW+1)'(qx_reg) + (QW+1)'(div_quo);
        if (qsum > (QW+1)'(32'sh7FFFFFFF))
        begin
            qsat = 32'h7FFFFFFF;
        end
        else if (qsum < -(QW+1)'(33'sh080000000))
        begin
            qsat = 32'h80000000;
        end
        else
        begin
            qsat = qsum[DW-1:0];
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lap5_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = lap5_pkg::ST_RD0;
                end
            end
            lap5_pkg::ST_RD0: state_next = lap5_pkg::ST_RD1;
            lap5_pkg::ST_RD1: state_next = lap5_pkg::ST_RD2;
            lap5_pkg::ST_RD2: state_next = lap5_pkg::ST_WR0;
            lap5_pkg::ST_WR0: state_next = lap5_pkg::ST_WR1;
            lap5_pkg::ST_WR1: state_next = lap5_pkg::ST_DIVX;
            lap5_pkg::ST_DIVX:
            begin
                if (div_stat.done)
                begin
                    state_next = lap5_pkg::ST_DIVZ;
                end
            end
            lap5_pkg::ST_DIVZ:
            begin
                if (div_stat.done)
                begin
                    state_next = lap5_pkg::ST_EMIT;
                end
            end
            lap5_pkg::ST_EMIT:
            begin
                if ((pend_reg == 4'd0) || (out_free && (pend_after == 4'd0)))
                begin
                    state_next = lap5_pkg::ST_IDLE;
                end
            end
            default: state_next = lap5_pkg::ST_IDLE;
        endcase
    end

    // Row store access, divider start and input stall per state.
    always_comb
    begin
        in_stall    = 1'b1;
        prev_we     = 1'b0;
        prev2_we    = 1'b0;
        prev_waddr  = c_reg - CW'(1);
        prev2_waddr = c_reg - CW'(1);
        prev_wdata  = left_old_reg;
        prev2_wdata = ce_reg;
        prev_raddr  = c_reg - CW'(1);
        prev2_raddr = c_reg - CW'(1);
        div_start   = 1'b0;
        div_num     = num_x;
        div_den     = sq_x;
        case (state_reg)
            lap5_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            lap5_pkg::ST_RD1:
            begin
                prev_raddr  = c_reg;
                prev2_raddr = c_reg - CW'(2);
            end
            lap5_pkg::ST_WR0:
            begin
                prev_we   = (c_reg != '0);
                prev2_we  = (c_reg != '0);
                div_start = 1'b1;
            end
            lap5_pkg::ST_WR1:
            begin
                prev_we     = last_col_reg;
                prev2_we    = last_col_reg;
                prev_waddr  = c_reg;
                prev2_waddr = c_reg;
                prev_wdata  = samp_reg;
                prev2_wdata = rt_reg;
            end
            lap5_pkg::ST_DIVX:
            begin
                div_start = div_stat.done;
                div_num   = num_z;
                div_den   = sq_z;
            end
            default:
            begin
            end
        endcase
    end

    // Configuration registers, frame position, sequencer state, pending mask and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= lap5_pkg::RST_IMAGE_WIDTH;
            image_height_reg <= lap5_pkg::RST_IMAGE_HEIGHT;
            step_x_reg       <= lap5_pkg::RST_GRID_STEP;
            step_z_reg       <= lap5_pkg::RST_GRID_STEP;
            row_count_reg    <= '0;
            col_count_reg    <= '0;
            left_sample_reg  <= '0;
            state_reg        <= lap5_pkg::ST_IDLE;
            pend_reg         <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    lap5_pkg::CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[10:0];
                    lap5_pkg::CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                    lap5_pkg::CFG_GRID_STEP_X:  step_x_reg       <= cfg_data[10:0];
                    lap5_pkg::CFG_GRID_STEP_Z:  step_z_reg       <= cfg_data[10:0];
                    default:
                    begin
                    end
                endcase
            end
            if (geo_write)
            begin
                row_count_reg   <= '0;
                col_count_reg   <= '0;
                left_sample_reg <= '0;
            end
            else if (accept)
            begin
                left_sample_reg <= sample;
                if ({1'b0, c_cl} + WW'(1) >= w_eff)
                begin
                    col_count_reg <= '0;
                    row_count_reg <= ({1'b0, r_cl} + 17'd1 >= {1'b0, h_eff}) ? '0 : r_cl + 16'd1;
                end
                else
                begin
                    col_count_reg <= c_cl + CW'(1);
                    row_count_reg <= r_cl;
                end
            end
            // Results due from this sample, in raster order.
            if (accept)
            begin
                pend_reg[0] <= (r_cl != '0) && (c_cl != '0);
                pend_reg[1] <= (r_cl != '0) && (c_cl != '0) && (c_cl == wlast);
                pend_reg[2] <= (r_cl == h_eff - 16'd1) && (c_cl != '0);
                pend_reg[3] <= (r_cl == h_eff - 16'd1) && (c_cl != '0) && (c_cl == wlast);
            end
            else if ((state_reg == lap5_pkg::ST_EMIT) && out_free && (pend_reg != 4'd0))
            begin
                pend_reg <= pend_after;
            end
            // Output register.
            if ((state_reg == lap5_pkg::ST_EMIT) && out_free && (pend_reg != 4'd0))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers of the datapath.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            samp_reg     <= sample;
            left_old_reg <= left_sample_reg;
            r_reg        <= r_cl;
            c_reg        <= c_cl;
            interior_reg <= (r_cl >= 16'd2) && (c_cl >= CW'(2));
            last_col_reg <= (c_cl == wlast);
        end
        if (state_reg == lap5_pkg::ST_RD1)
        begin
            ce_reg <= prev_rdata;
            up_reg <= prev2_rdata;
        end
        if (state_reg == lap5_pkg::ST_RD2)
        begin
            rt_reg <= prev_rdata;
            lf_reg <= prev2_rdata;
        end
        if ((state_reg == lap5_pkg::ST_DIVX) && div_stat.done)
        begin
            qx_reg <= div_quo;
        end
        if ((state_reg == lap5_pkg::ST_DIVZ) && div_stat.done)
        begin
            val_reg <= interior_reg ? qsat : '0;
        end
        if ((state_reg == lap5_pkg::ST_EMIT) && out_free && (pend_reg != 4'd0))
        begin
            lap_value_reg <= emit_val;
            out_row_reg   <= emit_row;
            out_col_reg   <= emit_col32[lap5_pkg::OUT_COL_W-1:0];
            run_last_reg  <= (pend_after == 4'd0);
        end
    end

    assign out_valid = out_valid_reg;
    assign lap_value = lap_value_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign run_last  = run_last_reg;

    // The divider is free whenever a new sample is taken.
    a_div_idle_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !div_stat.busy)
        else $error("divider busy when a sample was accepted");

    // The column position never reaches the effective width.
    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, col_count_reg} < w_eff))
        else $error("column counter beyond the row width");

    // No result is left behind when the sequencer returns to idle.
    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lap5_pkg::ST_IDLE) |-> (pend_reg == 4'd0))
        else $error("results pending while idle");

endmodule
